// File: hw/rtl/phkf_pkg.sv
// Package with the shared types, address map and hit program of the Kalman update block.
`timescale 1ns / 1ps
`default_nettype none
package phkf_pkg;

  localparam int WIDE_W    = 128;
  localparam int ADDR_W    = 6;
  localparam int MEM_DEPTH = 64;
  localparam int CHI2_W    = 32;
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 5;
  localparam int PC_W      = 7;
  localparam int NUM_ELEMS = 20;

  localparam logic [CHI2_W-1:0] CHI2_CUT_RESET = 32'd1638400;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_HIT   = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MAC,
    OP_MACN,
    OP_DET,
    OP_RECIP,
    OP_CHI2
  } op_t;

  typedef struct packed {
    op_t   op;
    addr_t dst;
    addr_t a0;
    addr_t b0;
    addr_t a1;
    addr_t b1;
  } instr_t;

  typedef struct packed {
    logic   capture;
    logic   wr;
    logic   rd;
    logic   start;
    logic   load_out;
    logic   ok;
    instr_t instr;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic singular;
    logic pass;
  } dp_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_EXEC,
    S_WAIT,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    P_IDLE,
    P_FETCH,
    P_MUL1,
    P_MUL2,
    P_DIV,
    P_WB
  } dp_phase_t;

  // Address map: 0..4 parameters, 5..19 covariance, then scratch values.
  localparam int C_BASE = 5;
  localparam int B_BASE = 36;
  localparam int K_BASE = 46;

  localparam addr_t A_P0   = 6'd0;
  localparam addr_t A_P1   = 6'd1;
  localparam addr_t A_C00  = 6'd5;
  localparam addr_t A_C01  = 6'd6;
  localparam addr_t A_C11  = 6'd10;
  localparam addr_t A_R0   = 6'd25;
  localparam addr_t A_R1   = 6'd26;
  localparam addr_t A_W00  = 6'd27;
  localparam addr_t A_W01  = 6'd28;
  localparam addr_t A_W11  = 6'd29;
  localparam addr_t A_INV  = 6'd30;
  localparam addr_t A_D00  = 6'd31;
  localparam addr_t A_D01  = 6'd32;
  localparam addr_t A_D11  = 6'd33;
  localparam addr_t A_U0   = 6'd34;
  localparam addr_t A_U1   = 6'd35;
  localparam addr_t A_TMP  = 6'd56;
  localparam addr_t A_M0   = 6'd57;
  localparam addr_t A_M1   = 6'd58;
  localparam addr_t A_VXX  = 6'd59;
  localparam addr_t A_VXY  = 6'd60;
  localparam addr_t A_VYY  = 6'd61;
  localparam addr_t A_ZERO = 6'd62;

  localparam logic [PC_W-1:0] STEP_DET  = 7'd5;
  localparam logic [PC_W-1:0] STEP_CHI2 = 7'd12;
  localparam logic [PC_W-1:0] STEP_LAST = 7'd72;

  function automatic int pack_idx(input int r, input int c);
    int rr;
    int cc;
    int start;
    rr = (r < c) ? r : c;
    cc = (r < c) ? c : r;
    case (rr)
      0: start = 0;
      1: start = 5;
      2: start = 9;
      3: start = 12;
      default: start = 14;
    endcase
    return start + cc - rr;
  endfunction

  function automatic int row_of(input int x);
    int r;
    case (x)
      0, 1, 2, 3, 4: r = 0;
      5, 6, 7, 8:    r = 1;
      9, 10, 11:     r = 2;
      12, 13:        r = 3;
      default:       r = 4;
    endcase
    return r;
  endfunction

  function automatic int col_of(input int x);
    int c;
    case (x)
      0:              c = 0;
      1, 5:           c = 1;
      2, 6, 9:        c = 2;
      3, 7, 10, 12:   c = 3;
      default:        c = 4;
    endcase
    return c;
  endfunction

  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t t;
    int s;
    int n;
    int i;
    int j;
    int x;
    s = int'(pc);
    n = 0;
    i = 0;
    j = 0;
    x = 0;
    t.op  = OP_ADD;
    t.dst = A_TMP;
    t.a0  = A_ZERO;
    t.b0  = A_ZERO;
    t.a1  = A_ZERO;
    t.b1  = A_ZERO;
    if (s == 0) begin
      t.op = OP_SUB; t.dst = A_R0; t.a0 = A_M0; t.a1 = A_P0;
    end else if (s == 1) begin
      t.op = OP_SUB; t.dst = A_R1; t.a0 = A_M1; t.a1 = A_P1;
    end else if (s == 2) begin
      t.dst = A_W00; t.a0 = A_C00; t.a1 = A_VXX;
    end else if (s == 3) begin
      t.dst = A_W01; t.a0 = A_C01; t.a1 = A_VXY;
    end else if (s == 4) begin
      t.dst = A_W11; t.a0 = A_C11; t.a1 = A_VYY;
    end else if (s == 5) begin
      t.op = OP_DET; t.a0 = A_W00; t.b0 = A_W11; t.a1 = A_W01; t.b1 = A_W01;
    end else if (s == 6) begin
      t.op = OP_RECIP; t.dst = A_INV;
    end else if (s == 7) begin
      t.op = OP_MAC; t.dst = A_D00; t.a0 = A_W11; t.b0 = A_INV;
    end else if (s == 8) begin
      t.op = OP_MACN; t.dst = A_D01; t.a0 = A_W01; t.b0 = A_INV;
    end else if (s == 9) begin
      t.op = OP_MAC; t.dst = A_D11; t.a0 = A_W00; t.b0 = A_INV;
    end else if (s == 10) begin
      t.op = OP_MAC; t.dst = A_U0;
      t.a0 = A_D00; t.b0 = A_R0; t.a1 = A_D01; t.b1 = A_R1;
    end else if (s == 11) begin
      t.op = OP_MAC; t.dst = A_U1;
      t.a0 = A_D01; t.b0 = A_R0; t.a1 = A_D11; t.b1 = A_R1;
    end else if (s == 12) begin
      t.op = OP_CHI2;
      t.a0 = A_U0; t.b0 = A_R0; t.a1 = A_U1; t.b1 = A_R1;
    end else if (s < 23) begin
      n = s - 13;
      i = n >> 1;
      j = n & 1;
      t.dst = addr_t'(B_BASE + n);
      t.a0  = addr_t'(C_BASE + pack_idx(j, i));
    end else if (s < 33) begin
      n = s - 23;
      i = n >> 1;
      j = n & 1;
      t.op  = OP_MAC;
      t.dst = addr_t'(K_BASE + n);
      t.a0  = addr_t'(B_BASE + 2 * i);
      t.a1  = addr_t'(B_BASE + 2 * i + 1);
      t.b0  = (j == 1) ? A_D01 : A_D00;
      t.b1  = (j == 1) ? A_D11 : A_D01;
    end else if (s < 43) begin
      n = s - 33;
      i = n >> 1;
      if ((n & 1) == 0) begin
        t.op = OP_MAC; t.dst = A_TMP;
        t.a0 = addr_t'(K_BASE + 2 * i); t.b0 = A_R0;
        t.a1 = addr_t'(K_BASE + 2 * i + 1); t.b1 = A_R1;
      end else begin
        t.dst = addr_t'(i); t.a0 = addr_t'(i); t.a1 = A_TMP;
      end
    end else if (s < 73) begin
      n = s - 43;
      x = n >> 1;
      i = row_of(x);
      j = col_of(x);
      if ((n & 1) == 0) begin
        t.op = OP_MACN; t.dst = A_TMP;
        t.a0 = addr_t'(K_BASE + 2 * i); t.b0 = addr_t'(B_BASE + 2 * j);
        t.a1 = addr_t'(K_BASE + 2 * i + 1); t.b1 = addr_t'(B_BASE + 2 * j + 1);
      end else begin
        t.dst = addr_t'(C_BASE + x); t.a0 = addr_t'(C_BASE + x); t.a1 = A_TMP;
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pixel_hit_kalman_update_2d_top.sv
// Top level of the two-dimensional pixel hit Kalman measurement update.
`timescale 1ns / 1ps
`default_nettype none
// The block holds one track's five parameters and packed covariance and takes
// one beat at a time. A write or a read passes through its own state and then
// the done state before the result beat is offered. A hit runs a fixed program
// of 73 steps on one shared arithmetic path: each step fetches its operands one
// per cycle from an entry memory with one read and one write port (or from the
// captured measurement), products come from a multiplier that sums four 32x32
// partial products, and the reciprocal of the determinant comes from a restoring
// divider. A rejected or singular hit stops early at the chi2 or determinant
// step. The next beat is taken while a result still waits at the output.
module pixel_hit_kalman_update_2d_top #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [phkf_pkg::CHI2_W-1:0]       cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [phkf_pkg::REQ_W-1:0]        req_type,
  input  wire logic [phkf_pkg::IDX_W-1:0]        elem_index,
  input  wire logic signed [VALUE_WIDTH-1:0]     elem_value,
  input  wire logic signed [VALUE_WIDTH-1:0]     meas_x,
  input  wire logic signed [VALUE_WIDTH-1:0]     meas_y,
  input  wire logic [VALUE_WIDTH-2:0]            meas_var_xx,
  input  wire logic signed [VALUE_WIDTH-1:0]     meas_var_xy,
  input  wire logic [VALUE_WIDTH-2:0]            meas_var_yy,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [VALUE_WIDTH-1:0]          read_value,
  output logic [phkf_pkg::CHI2_W-1:0]            chi2_value,
  output logic                                   accepted,
  output logic                                   status
);
  import phkf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  phkf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .req_type(req_type),
    .st(st), .cmd(cmd)
  );

  phkf_datapath #(.VW(VALUE_WIDTH), .FB(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req_type(req_type), .elem_index(elem_index), .elem_value(elem_value),
    .meas_x(meas_x), .meas_y(meas_y), .meas_var_xx(meas_var_xx),
    .meas_var_xy(meas_var_xy), .meas_var_yy(meas_var_yy),
    .cmd(cmd), .st(st), .read_value(read_value), .chi2_value(chi2_value),
    .accepted(accepted), .status(status)
  );

endmodule
`default_nettype wire

// File: hw/rtl/phkf_mul.sv
// Iterative signed multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module phkf_mul #(
  parameter int VW = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [VW-1:0]         a,
  input  wire logic signed [VW-1:0]         b,
  output logic                              done,
  output logic [phkf_pkg::WIDE_W-1:0]       prod
);
  import phkf_pkg::*;

  logic signed [63:0] a64;
  logic signed [63:0] b64;
  logic [63:0] ua;
  logic [63:0] ub;
  logic neg;
  logic busy;
  logic [2:0] cnt;
  logic [WIDE_W-1:0] acc;
  logic [31:0] ah;
  logic [31:0] bh;
  logic [63:0] pp;
  logic [WIDE_W-1:0] pp_sh;

  assign a64 = 64'(a);
  assign b64 = 64'(b);
  assign ah  = cnt[1] ? ua[63:32] : ua[31:0];
  assign bh  = cnt[0] ? ub[63:32] : ub[31:0];
  assign pp  = 64'(ah) * 64'(bh);

  always_comb begin
    case (cnt[1:0])
      2'd0: pp_sh = {64'd0, pp};
      2'd3: pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
        ua   <= a64[63] ? (64'd0 - a64) : a64;
        ub   <= b64[63] ? (64'd0 - b64) : b64;
        neg  <= a64[63] ^ b64[63];
        acc  <= '0;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          acc <= acc + pp_sh;
          cnt <= cnt + 3'd1;
        end else begin
          prod <= neg ? (WIDE_W'(0) - acc) : acc;
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/phkf_div.sv
// Restoring divider that forms the saturated reciprocal of the determinant.
`timescale 1ns / 1ps
`default_nettype none
module phkf_div #(
  parameter int VW = 48,
  parameter int FB = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [phkf_pkg::WIDE_W-1:0]  den,
  output logic                              done,
  output logic signed [VW-1:0]              quot
);
  import phkf_pkg::*;

  localparam int NUM_BIT = 3 * FB;
  localparam int CNT_W   = $clog2(NUM_BIT + 1);
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

  logic busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDE_W-1:0] rem;
  logic [WIDE_W-1:0] q;
  logic [WIDE_W-1:0] dreg;
  logic [WIDE_W:0] rsh;
  logic [WIDE_W:0] diff;
  logic ge;

  assign rsh  = {rem, (cnt == CNT_W'(NUM_BIT))};
  assign diff = rsh - {1'b0, dreg};
  assign ge   = ~diff[WIDE_W];
  assign quot = (|q[WIDE_W-1:VW-1]) ? VMAX : q[VW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_BIT);
        rem  <= '0;
        q    <= '0;
        dreg <= den;
      end else if (busy) begin
        rem <= ge ? diff[WIDE_W-1:0] : rsh[WIDE_W-1:0];
        q   <= {q[WIDE_W-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/phkf_datapath.sv
// Datapath with the entry memory, operand fetch, arithmetic units and result registers.
`timescale 1ns / 1ps
`default_nettype none
module phkf_datapath #(
  parameter int VW = 48,
  parameter int FB = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [phkf_pkg::CHI2_W-1:0]   cfg_wr_data,
  input  wire logic [phkf_pkg::REQ_W-1:0]    req_type,
  input  wire logic [phkf_pkg::IDX_W-1:0]    elem_index,
  input  wire logic signed [VW-1:0]          elem_value,
  input  wire logic signed [VW-1:0]          meas_x,
  input  wire logic signed [VW-1:0]          meas_y,
  input  wire logic [VW-2:0]                 meas_var_xx,
  input  wire logic signed [VW-1:0]          meas_var_xy,
  input  wire logic [VW-2:0]                 meas_var_yy,
  input  wire phkf_pkg::dp_cmd_t             cmd,
  output phkf_pkg::dp_status_t               st,
  output logic signed [VW-1:0]               read_value,
  output logic [phkf_pkg::CHI2_W-1:0]        chi2_value,
  output logic                               accepted,
  output logic                               status
);
  import phkf_pkg::*;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam int CHI2_SH = 2 * FB - 16;

  function automatic logic signed [VW-1:0] sat_vw(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VW:0] top;
    logic signed [VW-1:0] r;
    top = v[WIDE_W-1:VW-1];
    if ((&top) || !(|top)) r = v[VW-1:0];
    else r = v[WIDE_W-1] ? VMIN : VMAX;
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] adds(input logic signed [WIDE_W-1:0] x,
                                                    input logic signed [WIDE_W-1:0] y);
    logic signed [WIDE_W-1:0] s;
    s = x + y;
    if (x[WIDE_W-1] == y[WIDE_W-1] && s[WIDE_W-1] != x[WIDE_W-1])
      s = x[WIDE_W-1] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
    return s;
  endfunction

  logic [CHI2_W-1:0] cut;
  req_t req_q;
  logic [IDX_W-1:0] idx_q;
  logic signed [VW-1:0] val_q, m0_q, m1_q, vxx_q, vxy_q, vyy_q;
  logic signed [VW-1:0] mem [MEM_DEPTH];
  logic signed [VW-1:0] rdata;
  addr_t rsel;
  addr_t raddr;
  addr_t src;
  logic rd_en;
  logic signed [VW-1:0] operand;
  instr_t ins;
  dp_phase_t phase, phase_next;
  logic [2:0] fcnt;
  logic signed [VW-1:0] opr [4];
  logic signed [WIDE_W-1:0] p1, p2, det;
  logic sing;
  logic [CHI2_W-1:0] chi2;
  logic idx_ok;
  logic fetch_last;
  logic is_mul_op;

  logic mul_start, mul_done;
  logic signed [VW-1:0] mul_a, mul_b;
  logic [WIDE_W-1:0] mul_prod;
  logic div_start, div_done;
  logic signed [VW-1:0] div_q;

  logic signed [WIDE_W-1:0] wsum, mac_sum, det_now, cw, ea, eb;
  logic signed [VW-1:0] mac_val, add_val, wb_val;
  logic [CHI2_W-1:0] chi_now;
  logic sing_now;
  logic wb_we;
  logic mem_we;
  addr_t mem_waddr;
  logic signed [VW-1:0] mem_wdata;

  assign idx_ok     = (idx_q < IDX_W'(NUM_ELEMS));
  assign fetch_last = (phase == P_FETCH) && (fcnt == 3'd4);
  assign is_mul_op  = (ins.op != OP_ADD) && (ins.op != OP_SUB) && (ins.op != OP_RECIP);

  always_comb begin
    case (fcnt[1:0])
      2'd0: src = ins.a0;
      2'd1: src = ins.b0;
      2'd2: src = ins.a1;
      default: src = ins.b1;
    endcase
  end

  assign raddr = cmd.rd ? addr_t'(idx_q) : src;
  assign rd_en = cmd.rd || ((phase == P_FETCH) && (fcnt != 3'd4));

  always_comb begin
    case (rsel)
      A_M0:    operand = m0_q;
      A_M1:    operand = m1_q;
      A_VXX:   operand = vxx_q;
      A_VXY:   operand = vxy_q;
      A_VYY:   operand = vyy_q;
      A_ZERO:  operand = '0;
      default: operand = rdata;
    endcase
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      P_IDLE: if (cmd.start) phase_next = P_FETCH;
      P_FETCH: begin
        if (fcnt == 3'd4) begin
          if (ins.op == OP_ADD || ins.op == OP_SUB) phase_next = P_WB;
          else if (ins.op == OP_RECIP) phase_next = P_DIV;
          else phase_next = P_MUL1;
        end
      end
      P_MUL1: if (mul_done) phase_next = P_MUL2;
      P_MUL2: if (mul_done) phase_next = P_WB;
      P_DIV: if (div_done) phase_next = P_WB;
      P_WB: phase_next = P_IDLE;
      default: phase_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) phase <= P_IDLE;
    else phase <= phase_next;
  end

  assign mul_start = (fetch_last && is_mul_op) || ((phase == P_MUL1) && mul_done);
  assign mul_a     = (phase == P_MUL1) ? opr[2] : opr[0];
  assign mul_b     = (phase == P_MUL1) ? opr[3] : opr[1];
  assign div_start = fetch_last && (ins.op == OP_RECIP);

  phkf_mul #(.VW(VW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  phkf_div #(.VW(VW), .FB(FB)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .den(det),
    .done(div_done), .quot(div_q)
  );

  assign wsum    = adds(p1, p2);
  assign mac_sum = (ins.op == OP_MACN) ? (WIDE_W'(0) - wsum) : wsum;
  assign mac_val = sat_vw(mac_sum >>> FB);
  assign ea      = WIDE_W'(opr[0]);
  assign eb      = WIDE_W'(opr[2]);
  assign add_val = sat_vw((ins.op == OP_SUB) ? (ea - eb) : (ea + eb));
  assign det_now = p1 - p2;
  assign sing_now = opr[0][VW-1] || (opr[0] == '0) || det_now[WIDE_W-1] || (det_now == '0);
  assign cw      = wsum >>> CHI2_SH;
  assign chi_now = cw[WIDE_W-1] ? '0 : ((|cw[WIDE_W-1:CHI2_W]) ? '1 : cw[CHI2_W-1:0]);

  always_comb begin
    wb_val = '0;
    wb_we  = 1'b0;
    case (ins.op)
      OP_ADD, OP_SUB: begin wb_val = add_val; wb_we = 1'b1; end
      OP_MAC, OP_MACN: begin wb_val = mac_val; wb_we = 1'b1; end
      OP_RECIP: begin wb_val = div_q; wb_we = 1'b1; end
      default: begin wb_val = '0; wb_we = 1'b0; end
    endcase
  end

  assign mem_we    = (cmd.wr && idx_ok) || ((phase == P_WB) && wb_we);
  assign mem_waddr = cmd.wr ? addr_t'(idx_q) : ins.dst;
  assign mem_wdata = cmd.wr ? val_q : wb_val;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) begin
      rdata <= mem[raddr];
      rsel  <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cut <= CHI2_CUT_RESET;
    else if (cfg_wr_en) cut <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_t'(req_type);
      idx_q <= elem_index;
      val_q <= elem_value;
      m0_q  <= meas_x;
      m1_q  <= meas_y;
      vxx_q <= VW'(meas_var_xx);
      vxy_q <= meas_var_xy;
      vyy_q <= VW'(meas_var_yy);
      sing  <= 1'b0;
      chi2  <= '0;
    end
    if (cmd.start) begin
      ins  <= cmd.instr;
      fcnt <= 3'd0;
    end
    if (phase == P_FETCH) begin
      fcnt <= fcnt + 3'd1;
      if (fcnt != 3'd0) opr[2'(fcnt - 3'd1)] <= operand;
    end
    if ((phase == P_MUL1) && mul_done) p1 <= mul_prod;
    if ((phase == P_MUL2) && mul_done) p2 <= mul_prod;
    if (phase == P_WB) begin
      if (ins.op == OP_DET) begin
        det  <= det_now;
        sing <= sing_now;
      end
      if (ins.op == OP_CHI2) chi2 <= chi_now;
    end
    if (cmd.load_out) begin
      read_value <= ((req_q == REQ_READ) && idx_ok) ? rdata : '0;
      chi2_value <= chi2;
      accepted   <= cmd.ok;
      status     <= sing;
    end
  end

  assign st.done     = (phase == P_WB);
  assign st.singular = sing_now;
  assign st.pass     = (chi_now < cut);

endmodule
`default_nettype wire

// File: hw/rtl/phkf_ctrl.sv
// Controller state machine that sequences requests and the hit program.
`timescale 1ns / 1ps
`default_nettype none
module phkf_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  input  wire logic [phkf_pkg::REQ_W-1:0]  req_type,
  input  wire phkf_pkg::dp_status_t        st,
  output phkf_pkg::dp_cmd_t                cmd
);
  import phkf_pkg::*;

  ctrl_state_t state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic ok, ok_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      ok        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      ok        <= ok_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    ok_next    = ok;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.instr  = prog(pc);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          ok_next     = 1'b0;
          case (req_t'(req_type))
            REQ_WRITE: state_next = S_WRITE;
            REQ_READ:  state_next = S_READ;
            REQ_HIT: begin
              state_next = S_EXEC;
              pc_next    = '0;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = S_DONE;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_DONE;
      end
      S_EXEC: begin
        cmd.start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (st.done) begin
          if (((pc == STEP_DET) && st.singular) || ((pc == STEP_CHI2) && !st.pass)) begin
            state_next = S_DONE;
          end else if (pc == STEP_LAST) begin
            ok_next    = 1'b1;
            state_next = S_DONE;
          end else begin
            pc_next    = pc + PC_W'(1);
            state_next = S_EXEC;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          cmd.ok       = ok;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= STEP_LAST)
    else $error("Program counter ran past the last step.");
  a_exec_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (state == S_WAIT))
    else $error("Instruction start did not enter the wait state.");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("Result loaded over a beat that was not taken.");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    st.done |-> (state == S_WAIT))
    else $error("Datapath finished an instruction that was not issued.");

endmodule
`default_nettype wire

// File: sim/pixel_hit_kalman_update_2d_top_test.sv
// Self-checking testbench of the 2D pixel hit Kalman measurement update block.
`timescale 1ns / 1ps
module pixel_hit_kalman_update_2d_top_test;
  import phkf_pkg::*;

  localparam int VW = 48;
  localparam int FB = 24;
  localparam int CYCLE_LIMIT = 6000000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [VW-1:0] val_t;

  typedef struct {
    req_t req;
    logic [IDX_W-1:0] idx;
    val_t val;
    val_t mx;
    val_t my;
    logic [VW-2:0] vxx;
    val_t vxy;
    logic [VW-2:0] vyy;
  } beat_t;

  typedef struct {
    val_t rd;
    logic [CHI2_W-1:0] chi2;
    logic acc;
    logic st;
  } answer_t;

  localparam int SYM_IDX [5][5] = '{'{0, 1, 2, 3, 4}, '{1, 5, 6, 7, 8}, '{2, 6, 9, 10, 11},
                                    '{3, 7, 10, 12, 13}, '{4, 8, 11, 13, 14}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CHI2_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] req_type = '0;
  logic [IDX_W-1:0] elem_index = '0;
  val_t elem_value = '0;
  val_t meas_x = '0;
  val_t meas_y = '0;
  logic [VW-2:0] meas_var_xx = '0;
  val_t meas_var_xy = '0;
  logic [VW-2:0] meas_var_yy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  val_t read_value;
  logic [CHI2_W-1:0] chi2_value;
  logic accepted;
  logic status;

  beat_t pending_beats[$];
  answer_t expected_answers[$];
  val_t track_elems[NUM_ELEMS];
  logic [CHI2_W-1:0] model_cut = CHI2_CUT_RESET;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  beat_t cur_beat;

  pixel_hit_kalman_update_2d_top #(.VALUE_WIDTH(VW), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .elem_index(elem_index), .elem_value(elem_value), .meas_x(meas_x), .meas_y(meas_y),
    .meas_var_xx(meas_var_xx), .meas_var_xy(meas_var_xy), .meas_var_yy(meas_var_yy),
    .out_valid(out_valid), .out_ready(out_ready), .read_value(read_value),
    .chi2_value(chi2_value), .accepted(accepted), .status(status)
  );

  always #5 clk = ~clk;

  function automatic val_t clamp_val(wide_t a);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (VW - 1)) - 1;
    lo = -hi - 1;
    if (a > hi) return hi[VW-1:0];
    if (a < lo) return lo[VW-1:0];
    return a[VW-1:0];
  endfunction

  function automatic val_t rescale(wide_t a);
    return clamp_val(a >>> FB);
  endfunction

  function automatic wide_t full_prod(val_t a, val_t b);
    return wide_t'(a) * wide_t'(b);
  endfunction

  function automatic wide_t sum_clamped(wide_t a, wide_t b);
    wide_t r;
    r = a + b;
    if (a[127] == b[127] && r[127] != a[127])
      r = a[127] ? {1'b1, 127'd0} : {1'b0, {127{1'b1}}};
    return r;
  endfunction

  function automatic val_t dot2(val_t a0, val_t b0, val_t a1, val_t b1, bit negate);
    wide_t s;
    s = sum_clamped(full_prod(a0, b0), full_prod(a1, b1));
    if (negate) s = -s;
    return rescale(s);
  endfunction

  function automatic val_t add_clamped(val_t a, val_t b);
    return clamp_val(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic answer_t kalman_predict(beat_t b);
    answer_t ans;
    val_t cov [15];
    val_t r0, r1, w00, w01, w11, inv, d00, d01, d11, u0, u1;
    val_t bm [5][2];
    val_t km [5][2];
    val_t dm [2][2];
    wide_t det, cw;
    logic [127:0] quot;
    ans = '{rd: '0, chi2: '0, acc: 1'b0, st: 1'b0};
    case (b.req)
      REQ_WRITE: if (b.idx < NUM_ELEMS) track_elems[b.idx] = b.val;
      REQ_READ: if (b.idx < NUM_ELEMS) ans.rd = track_elems[b.idx];
      REQ_HIT: begin
        for (int i = 0; i < 15; i++) cov[i] = track_elems[5 + i];
        r0 = clamp_val(wide_t'(b.mx) - wide_t'(track_elems[0]));
        r1 = clamp_val(wide_t'(b.my) - wide_t'(track_elems[1]));
        w00 = add_clamped(cov[0], val_t'({1'b0, b.vxx}));
        w01 = add_clamped(cov[1], b.vxy);
        w11 = add_clamped(cov[5], val_t'({1'b0, b.vyy}));
        det = full_prod(w00, w11) - full_prod(w01, w01);
        if (w00 <= 0 || det <= 0) begin
          ans.st = 1'b1;
          return ans;
        end
        quot = (128'd1 << (3 * FB)) / 128'(det);
        inv = (quot > 128'((128'd1 << (VW - 1)) - 1)) ? {1'b0, {(VW-1){1'b1}}} : quot[VW-1:0];
        d00 = rescale(full_prod(w11, inv));
        d01 = rescale(-full_prod(w01, inv));
        d11 = rescale(full_prod(w00, inv));
        dm = '{'{d00, d01}, '{d01, d11}};
        u0 = dot2(d00, r0, d01, r1, 1'b0);
        u1 = dot2(d01, r0, d11, r1, 1'b0);
        cw = sum_clamped(full_prod(u0, r0), full_prod(u1, r1)) >>> (2 * FB - 16);
        if (cw < 0) ans.chi2 = '0;
        else if (cw > 128'hFFFF_FFFF) ans.chi2 = '1;
        else ans.chi2 = cw[31:0];
        if (!(ans.chi2 < model_cut)) return ans;
        ans.acc = 1'b1;
        for (int i = 0; i < 5; i++) begin
          bm[i][0] = cov[SYM_IDX[0][i]];
          bm[i][1] = cov[SYM_IDX[1][i]];
        end
        for (int i = 0; i < 5; i++)
          for (int j = 0; j < 2; j++)
            km[i][j] = dot2(bm[i][0], dm[0][j], bm[i][1], dm[1][j], 1'b0);
        for (int i = 0; i < 5; i++)
          track_elems[i] = add_clamped(track_elems[i], dot2(km[i][0], r0, km[i][1], r1, 1'b0));
        for (int i = 0; i < 5; i++)
          for (int j = i; j < 5; j++)
            track_elems[5 + SYM_IDX[i][j]] = add_clamped(cov[SYM_IDX[i][j]],
                dot2(km[i][0], bm[j][0], km[i][1], bm[j][1], 1'b1));
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic val_t rand_full();
    return val_t'({$urandom, $urandom});
  endfunction

  function automatic val_t rand_mid(int lo_bits, int hi_bits, bit pos);
    val_t v;
    v = rand_full() >>> (VW - $urandom_range(hi_bits, lo_bits));
    if (pos && v < 0) v = -v;
    return ($urandom_range(99) < 12) ? rand_full() : v;
  endfunction

  task automatic push_beat(req_t req, int idx, val_t val, val_t mx, val_t my,
                           val_t vxx, val_t vxy, val_t vyy);
    beat_t b;
    b = '{req: req, idx: idx[IDX_W-1:0], val: val, mx: mx, my: my,
          vxx: vxx[VW-2:0], vxy: vxy, vyy: vyy[VW-2:0]};
    pending_beats.push_back(b);
  endtask

  task automatic push_track();
    for (int i = 0; i < NUM_ELEMS; i++) begin
      if (i == 5 || i == 10 || i == 14 || i == 17 || i == 19)
        push_beat(REQ_WRITE, i, rand_mid(18, 28, 1'b1), 0, 0, 0, 0, 0);
      else
        push_beat(REQ_WRITE, i, rand_mid(10, 26, 1'b0), 0, 0, 0, 0, 0);
    end
  endtask

  task automatic push_hit();
    push_beat(REQ_HIT, $urandom_range(31), rand_full(), rand_mid(10, 30, 1'b0),
              rand_mid(10, 30, 1'b0), rand_mid(14, 28, 1'b1), rand_mid(8, 22, 1'b0),
              rand_mid(14, 28, 1'b1));
  endtask

  task automatic push_random_phase(int n);
    int start;
    start = pending_beats.size();
    while (pending_beats.size() - start < n) begin
      if ($urandom_range(99) < 80) begin
        push_track();
        repeat ($urandom_range(5, 2)) begin
          push_hit();
          if ($urandom_range(1)) push_beat(REQ_READ, $urandom_range(19), rand_full(),
                                           0, 0, 0, 0, 0);
        end
        repeat ($urandom_range(3)) push_beat(REQ_READ, $urandom_range(31), rand_full(),
                                             rand_full(), rand_full(), rand_full(), 0, 0);
      end else begin
        repeat ($urandom_range(6, 2)) begin
          case ($urandom_range(3))
            0: push_beat(REQ_WRITE, $urandom_range(31), rand_full(), rand_full(),
                         rand_full(), rand_full(), rand_full(), rand_full());
            1: push_beat(REQ_READ, $urandom_range(31), rand_full(), rand_full(),
                         rand_full(), rand_full(), rand_full(), rand_full());
            2: push_beat(REQ_HIT, $urandom_range(31), rand_full(), rand_full(),
                         rand_full(), rand_full(), rand_full(), rand_full());
            default: push_beat(REQ_NOP, $urandom_range(31), rand_full(), rand_full(),
                               rand_full(), rand_full(), rand_full(), rand_full());
          endcase
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cut(logic [CHI2_W-1:0] cut);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cut;
    model_cut = cut;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_answers.push_back(kalman_predict(cur_beat));
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_beat.req;
          elem_index <= cur_beat.idx;
          elem_value <= cur_beat.val;
          meas_x <= cur_beat.mx;
          meas_y <= cur_beat.my;
          meas_var_xx <= cur_beat.vxx;
          meas_var_xy <= cur_beat.vxy;
          meas_var_yy <= cur_beat.vyy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (hold_start) hold_left <= 4000;
  end

  always @(posedge clk) begin
    answer_t exp_ans;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("result beat with no expectation pending");
          errors++;
        end else begin
          exp_ans = expected_answers.pop_front();
          if (read_value !== exp_ans.rd) begin
            $error("read_value: expected %0h, got %0h", exp_ans.rd, read_value);
            errors++;
          end
          if (chi2_value !== exp_ans.chi2) begin
            $error("chi2_value: expected %0h, got %0h", exp_ans.chi2, chi2_value);
            errors++;
          end
          if (accepted !== exp_ans.acc) begin
            $error("accepted: expected %0b, got %0b", exp_ans.acc, accepted);
            errors++;
          end
          if (status !== exp_ans.st) begin
            $error("status: expected %0b, got %0b", exp_ans.st, status);
            errors++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    val_t vmax;
    val_t vmin;
    vmax = {1'b0, {(VW-1){1'b1}}};
    vmin = {1'b1, {(VW-1){1'b0}}};
    for (int i = 0; i < NUM_ELEMS; i++) track_elems[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 7;
    recv_idle_pct = 80;
    for (int i = 0; i < NUM_ELEMS; i++) push_beat(REQ_WRITE, i, 0, 0, 0, 0, 0, 0);
    push_beat(REQ_HIT, 0, 0, 0, 0, 0, 0, 0);
    push_beat(REQ_WRITE, 2, vmax, 0, 0, 0, 0, 0);
    push_beat(REQ_WRITE, 3, vmin, 0, 0, 0, 0, 0);
    push_beat(REQ_READ, 2, 0, 0, 0, 0, 0, 0);
    push_beat(REQ_READ, 3, 0, 0, 0, 0, 0, 0);
    push_beat(REQ_WRITE, 25, vmax, 0, 0, 0, 0, 0);
    push_beat(REQ_READ, 31, 0, 0, 0, 0, 0, 0);
    push_beat(REQ_NOP, 7, vmin, vmax, vmin, vmax, vmin, vmax);
    push_beat(REQ_WRITE, 5, 48'sd1 <<< 24, 0, 0, 0, 0, 0);
    push_beat(REQ_WRITE, 10, 48'sd1 <<< 24, 0, 0, 0, 0, 0);
    push_beat(REQ_HIT, 0, 0, 48'sd1 <<< 23, -(48'sd1 <<< 23), 48'sd1 <<< 24, 0, 48'sd1 <<< 24);
    push_beat(REQ_HIT, 0, 0, vmax, vmin, 1, 0, 1);
    push_beat(REQ_HIT, 0, 0, 0, 0, vmax, vmax, vmax);
    push_beat(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
    push_beat(REQ_READ, 19, 0, 0, 0, 0, 0, 0);
    wait_drained();
    push_random_phase(450);
    wait_drained();
    write_cut(32'hFFFF_FFFF);

    send_idle_pct = 80;
    recv_idle_pct = 7;
    push_random_phase(450);
    wait_drained();
    write_cut($urandom_range(32'h0020_0000));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    push_random_phase(450);
    wait_drained();
    write_cut(32'd0);
    push_random_phase(150);
    wait_drained();
    write_cut($urandom);
    push_random_phase(300);
    wait_drained();
    repeat (100) @(posedge clk);

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/phkf_pkg.sv
hw/rtl/phkf_mul.sv
hw/rtl/phkf_div.sv
hw/rtl/phkf_datapath.sv
hw/rtl/phkf_ctrl.sv
hw/rtl/pixel_hit_kalman_update_2d_top.sv
sim/pixel_hit_kalman_update_2d_top_test.sv
